// ===== hw/rtl/session_table_with_aging_assert.svh =====
// ----------------------------------------------------------------------------
// Session table assertion macros
// Concurrent assertion shorthands clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SESSION_TABLE_WITH_AGING_ASSERT_SVH
`define SESSION_TABLE_WITH_AGING_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SESS_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("session table assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SESS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("session table assertion failed");

`endif

// ===== hw/rtl/sess_pkg.sv =====
// ----------------------------------------------------------------------------
// Session table package
// Field widths, operation and status codes, and the types shared by the
// session table modules.
// ----------------------------------------------------------------------------
package sess_pkg;

    localparam int DEF_CAPACITY = 64;
    localparam int ID_W         = 32;
    localparam int FUNC_W       = 3;
    localparam int INDEX_W      = 6;
    localparam int SLOT_OUT_W   = 6;
    localparam int CNT_OUT_W    = 7;
    localparam logic [ID_W-1:0] EXPIRE_RESET = 32'd3600;

    typedef enum logic [FUNC_W-1:0] {
        FN_CREATE = 3'd0,
        FN_FIND   = 3'd1,
        FN_REMOVE = 3'd2,
        FN_EXPIRE = 3'd3,
        FN_READ   = 3'd4
    } func_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_FULL      = 3'd2,
        ST_BAD_ID    = 3'd3,
        ST_BAD_INDEX = 3'd4
    } status_t;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [ID_W-1:0] user;
        logic [ID_W-1:0] stamp;
    } entry_t;

    typedef struct packed {
        status_t               status;
        logic [SLOT_OUT_W-1:0] slot;
        logic [ID_W-1:0]       id;
        logic [ID_W-1:0]       user;
        logic [ID_W-1:0]       stamp;
        logic [CNT_OUT_W-1:0]  removed;
        logic [CNT_OUT_W-1:0]  count;
    } res_t;

endpackage

// ===== hw/rtl/sess_mem.sv =====
// ----------------------------------------------------------------------------
// Session entry memory
// Single write port, single read port; read data is registered, so it
// appears in the cycle after the address.
// ----------------------------------------------------------------------------
module sess_mem
    import sess_pkg::*;
#(
    parameter int DEPTH  = DEF_CAPACITY,
    parameter int ADDR_W = 6
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  entry_t            wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output entry_t            rd_data
);

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/sess_ctrl.sv =====
// ----------------------------------------------------------------------------
// Session table sequencer
// Takes one operation at a time, scans the entry memory one slot per cycle,
// compacts it on remove and expire, and holds the result until it is taken.
// ----------------------------------------------------------------------------
module sess_ctrl
    import sess_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int SLOT_W   = 6,
    parameter int CNT_W    = 7
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [FUNC_W-1:0]  func,
    input  logic [ID_W-1:0]    session_id,
    input  logic [ID_W-1:0]    candidate_id,
    input  logic [ID_W-1:0]    user_id,
    input  logic [ID_W-1:0]    now_seconds,
    input  logic [INDEX_W-1:0] entry_index,
    input  logic [ID_W-1:0]    expire_seconds,
    output logic               res_valid,
    input  logic               res_take,
    output res_t               res,
    output logic               wr_en,
    output logic [SLOT_W-1:0]  wr_addr,
    output entry_t             wr_data,
    output logic               rd_en,
    output logic [SLOT_W-1:0]  rd_addr,
    input  entry_t             rd_data
);

    localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_FETCH = 4'b0100,
        S_RESP  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    func_t             op_reg, op_next;
    logic [ID_W-1:0]   key_reg, key_next;
    logic [ID_W-1:0]   user_reg, user_next;
    logic [ID_W-1:0]   now_reg, now_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic [SLOT_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  removed_reg, removed_next;
    logic              move_reg, move_next;
    res_t              res_reg, res_next;

    func_t             in_op;
    logic [ID_W-1:0]   age;
    logic              hit;
    logic [CNT_W-1:0]  cur_inc;
    logic [CNT_W-1:0]  count_dec;
    logic              idx_ok;

    assign in_op     = func_t'(func);
    assign age       = now_reg - rd_data.stamp;
    assign hit       = (op_reg == FN_EXPIRE) ? (age > expire_seconds)
                                             : (rd_data.id == key_reg);
    assign cur_inc   = CNT_W'(cur_reg) + 1'b1;
    assign count_dec = count_reg - 1'b1;
    assign idx_ok    = CMP_W'(entry_index) < CMP_W'(count_reg);

    assign in_stall  = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_RESP);
    assign res       = res_reg;

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        user_next    = user_reg;
        now_next     = now_reg;
        idx_next     = idx_reg;
        cur_next     = cur_reg;
        count_next   = count_reg;
        removed_next = removed_reg;
        move_next    = move_reg;
        res_next     = res_reg;
        rd_en        = 1'b0;
        rd_addr      = cur_reg;
        wr_en        = 1'b0;
        wr_addr      = cur_reg;
        wr_data      = rd_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next      = in_op;
                    key_next     = (in_op == FN_CREATE) ? candidate_id : session_id;
                    user_next    = user_id;
                    now_next     = now_seconds;
                    idx_next     = SLOT_W'(entry_index);
                    cur_next     = '0;
                    removed_next = '0;
                    move_next    = 1'b0;
                    res_next     = '0;
                    state_next   = S_RESP;
                    unique case (in_op) inside
                        FN_CREATE:
                        begin
                            if (count_reg >= CNT_W'(CAPACITY))
                            begin
                                res_next.status = ST_FULL;
                            end
                            else if (candidate_id == '0)
                            begin
                                res_next.status = ST_BAD_ID;
                            end
                            else if (count_reg == '0)
                            begin
                                wr_en            = 1'b1;
                                wr_addr          = '0;
                                wr_data          = '{candidate_id, user_id, now_seconds};
                                count_next       = count_reg + 1'b1;
                                res_next.status  = ST_OK;
                                res_next.id      = candidate_id;
                                res_next.user    = user_id;
                                res_next.stamp   = now_seconds;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                state_next = S_SCAN;
                            end
                        end
                        FN_FIND, FN_REMOVE, FN_EXPIRE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = (in_op == FN_EXPIRE) ? ST_OK : ST_NOT_FOUND;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                state_next = S_SCAN;
                            end
                        end
                        FN_READ:
                        begin
                            if (idx_ok)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = SLOT_W'(entry_index);
                                state_next = S_FETCH;
                            end
                            else
                            begin
                                res_next.status = ST_BAD_INDEX;
                            end
                        end
                        default:
                        begin
                            res_next.status = ST_OK;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // A pending move lands the old last entry in the slot under test.
                if (move_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = cur_reg;
                    wr_data = rd_data;
                end
                unique case (op_reg) inside
                    FN_FIND, FN_CREATE:
                    begin
                        if (hit)
                        begin
                            state_next = S_RESP;
                            if (op_reg == FN_FIND)
                            begin
                                res_next.status = ST_OK;
                                res_next.slot   = SLOT_OUT_W'(cur_reg);
                                res_next.id     = rd_data.id;
                                res_next.user   = rd_data.user;
                                res_next.stamp  = rd_data.stamp;
                            end
                            else
                            begin
                                res_next.status = ST_BAD_ID;
                            end
                        end
                        else if (cur_inc < count_reg)
                        begin
                            rd_en    = 1'b1;
                            rd_addr  = SLOT_W'(cur_inc);
                            cur_next = SLOT_W'(cur_inc);
                        end
                        else
                        begin
                            state_next = S_RESP;
                            if (op_reg == FN_FIND)
                            begin
                                res_next.status = ST_NOT_FOUND;
                            end
                            else
                            begin
                                wr_en           = 1'b1;
                                wr_addr         = SLOT_W'(count_reg);
                                wr_data         = '{key_reg, user_reg, now_reg};
                                count_next      = count_reg + 1'b1;
                                res_next.status = ST_OK;
                                res_next.slot   = SLOT_OUT_W'(count_reg);
                                res_next.id     = key_reg;
                                res_next.user   = user_reg;
                                res_next.stamp  = now_reg;
                            end
                        end
                    end
                    FN_REMOVE, FN_EXPIRE:
                    begin
                        if (hit)
                        begin
                            removed_next = removed_reg + 1'b1;
                            count_next   = count_dec;
                            if (CNT_W'(cur_reg) < count_dec)
                            begin
                                rd_en     = 1'b1;
                                rd_addr   = SLOT_W'(count_dec);
                                move_next = 1'b1;
                            end
                            else
                            begin
                                move_next  = 1'b0;
                                state_next = S_RESP;
                            end
                        end
                        else
                        begin
                            move_next = 1'b0;
                            if (cur_inc < count_reg)
                            begin
                                rd_en    = 1'b1;
                                rd_addr  = SLOT_W'(cur_inc);
                                cur_next = SLOT_W'(cur_inc);
                            end
                            else
                            begin
                                state_next = S_RESP;
                            end
                        end
                        if (state_next == S_RESP)
                        begin
                            res_next.status = (op_reg == FN_REMOVE && removed_next == '0)
                                              ? ST_NOT_FOUND : ST_OK;
                        end
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end

            S_FETCH:
            begin
                res_next.status = ST_OK;
                res_next.slot   = SLOT_OUT_W'(idx_reg);
                res_next.id     = rd_data.id;
                res_next.user   = rd_data.user;
                res_next.stamp  = rd_data.stamp;
                state_next      = S_RESP;
            end

            S_RESP:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (state_next == S_RESP && state_reg != S_RESP)
        begin
            res_next.count   = CNT_OUT_W'(count_next);
            res_next.removed = CNT_OUT_W'(removed_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            move_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            move_reg  <= move_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        user_reg    <= user_next;
        now_reg     <= now_next;
        idx_reg     <= idx_next;
        cur_reg     <= cur_next;
        removed_reg <= removed_next;
        res_reg     <= res_next;
    end

endmodule

// ===== hw/rtl/session_table_with_aging.sv =====
// ----------------------------------------------------------------------------
// Session table with aging
// Unordered table of sessions held compactly in one entry memory, with
// create, find, remove, expire sweep and read by index.
//
//   Channel   Handshake                    Beat contents
//   input     in_valid / in_stall          func, ids, time, entry_index
//   output    out_valid / out_stall        status, entry, counts
//   config    cfg_wr_en / cfg_wr_data      expire_seconds
//
// Create and find stop at the first match, while remove and expire scan every
// live entry and read by index fetches one slot; every live entry is tested
// once, and the single read port of the entry memory sets one slot per cycle.
// Reset clears the live count and sets expire_seconds to 3600; the memory
// itself is not cleared. A result waits in the output register while the
// next beat is accepted; that beat's result is held until the register frees.
// ----------------------------------------------------------------------------
module session_table_with_aging
    import sess_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [ID_W-1:0]       cfg_wr_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [FUNC_W-1:0]     func,
    input  logic [ID_W-1:0]       session_id,
    input  logic [ID_W-1:0]       candidate_id,
    input  logic [ID_W-1:0]       user_id,
    input  logic [ID_W-1:0]       now_seconds,
    input  logic [INDEX_W-1:0]    entry_index,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [2:0]            status,
    output logic [SLOT_OUT_W-1:0] entry_slot,
    output logic [ID_W-1:0]       found_id,
    output logic [ID_W-1:0]       found_user,
    output logic [ID_W-1:0]       found_time,
    output logic [CNT_OUT_W-1:0]  removed_count,
    output logic [CNT_OUT_W-1:0]  entry_count
);

    localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    logic [ID_W-1:0]   expire_reg;
    logic              out_valid_reg;
    res_t              out_reg;
    logic              res_valid;
    logic              res_take;
    res_t              res;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    entry_t            wr_data;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    entry_t            rd_data;

    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expire_reg    <= EXPIRE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                expire_reg <= cfg_wr_data;
            end
            if (res_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_reg.status;
    assign entry_slot    = out_reg.slot;
    assign found_id      = out_reg.id;
    assign found_user    = out_reg.user;
    assign found_time    = out_reg.stamp;
    assign removed_count = out_reg.removed;
    assign entry_count   = out_reg.count;

    sess_ctrl #(
        .CAPACITY (CAPACITY),
        .SLOT_W   (SLOT_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .session_id     (session_id),
        .candidate_id   (candidate_id),
        .user_id        (user_id),
        .now_seconds    (now_seconds),
        .entry_index    (entry_index),
        .expire_seconds (expire_reg),
        .res_valid      (res_valid),
        .res_take       (res_take),
        .res            (res),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr),
        .rd_data        (rd_data)
    );

    sess_mem #(
        .DEPTH  (CAPACITY),
        .ADDR_W (SLOT_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

// ===== hw/rtl/sess_chk.sv =====
// ----------------------------------------------------------------------------
// Session table port checker
// Watches the result channel of the session table and checks how results
// relate to each other and to the table size over time.
// ----------------------------------------------------------------------------
`include "session_table_with_aging_assert.svh"

module sess_chk
    import sess_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [2:0]            status,
    input logic [SLOT_OUT_W-1:0] entry_slot,
    input logic [ID_W-1:0]       found_id,
    input logic [ID_W-1:0]       found_user,
    input logic [ID_W-1:0]       found_time,
    input logic [CNT_OUT_W-1:0]  removed_count,
    input logic [CNT_OUT_W-1:0]  entry_count
);

    localparam logic [CNT_OUT_W-1:0] FULL_COUNT = CNT_OUT_W'(CAPACITY);

    logic                         held_beat;
    logic [3+2*CNT_OUT_W-1:0]     beat_fields;
    logic                         failed_beat;
    logic                         no_entry;

    assign held_beat   = out_valid && out_stall;
    assign beat_fields = {status, removed_count, entry_count};
    assign failed_beat = out_valid && (status == ST_NOT_FOUND || status == ST_FULL
                                       || status == ST_BAD_ID || status == ST_BAD_INDEX);
    assign no_entry    = (entry_slot == '0) && (found_id == '0) && (found_user == '0)
                         && (found_time == '0);

    // A stalled result beat keeps its status and counts.
    `SESS_ASSERT_NEXT(a_out_hold, held_beat, out_valid && $stable(beat_fields))

    // Failed operations report no entry.
    `SESS_ASSERT_IMPLY(a_fail_no_entry, failed_beat, no_entry)

    // A full table reports the whole capacity as live.
    `SESS_ASSERT_IMPLY(a_full_count, out_valid && status == ST_FULL, entry_count == FULL_COUNT)

    // Nothing is removed by an operation that fails.
    `SESS_ASSERT_IMPLY(a_fail_no_removal, out_valid && status != ST_OK, removed_count == '0)

endmodule

bind session_table_with_aging sess_chk #(.CAPACITY(CAPACITY)) u_sess_chk (.*);
